FILE: rtl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants for the UTF-16 to UTF-8 byte encoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int MAX_BYTES = 6;
  localparam int CNT_W     = 3;
  localparam int SEG_BYTES = 4;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  // register index (paddr[ADDR_W-1:2])
  localparam logic [ADDR_W-3:0] REG_EMIT_UTF8 = '0;

  // top six bits of a surrogate code unit
  localparam logic [5:0] HIGH_SURR_TAG = 6'h36;
  localparam logic [5:0] LOW_SURR_TAG  = 6'h37;

  localparam logic [7:0] UTF8_BOM0  = 8'hef;
  localparam logic [7:0] UTF8_BOM1  = 8'hbb;
  localparam logic [7:0] UTF8_BOM2  = 8'hbf;
  localparam logic [7:0] UTF16_BOM0 = 8'hfe;
  localparam logic [7:0] UTF16_BOM1 = 8'hff;
  localparam logic [7:0] LEAD2      = 8'hc0;
  localparam logic [7:0] LEAD3      = 8'he0;
  localparam logic [7:0] LEAD4      = 8'hf0;
  localparam logic [7:0] CONT       = 8'h80;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        first_unit;
    logic        last_unit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
  } out_item_t;

  typedef logic [MAX_BYTES-1:0][7:0] byte_list_t;

  // encoder result for one request
  typedef struct packed {
    byte_list_t       bytes;
    logic [CNT_W-1:0] count;
    logic             hold;
  } enc_res_t;

endpackage

FILE: rtl/u16u8_encode.sv
// ----------------------------------------------------------------------------
// u16u8_encode
// Combinational encoder: one code unit plus held state to a list of bytes.
// ----------------------------------------------------------------------------
module u16u8_encode
  import u16u8_pkg::*;
(
  input  in_item_t    item,
  input  logic        emit_utf8,
  input  logic        held_valid,
  input  logic [15:0] held_high,
  output enc_res_t    res
);

  typedef struct packed {
    logic [SEG_BYTES-1:0][7:0] b;
    logic [CNT_W-1:0]          n;
  } seg_t;

  function automatic seg_t enc_unit(input logic [15:0] u);
    seg_t s;
    s = '0;
    if (u[15:7] == '0) begin
      s.b[0] = u[7:0];
      s.n    = 3'd1;
    end else if (u[15:11] == '0) begin
      s.b[0] = LEAD2 | {3'b000, u[10:6]};
      s.b[1] = CONT | {2'b00, u[5:0]};
      s.n    = 3'd2;
    end else begin
      s.b[0] = LEAD3 | {4'h0, u[15:12]};
      s.b[1] = CONT | {2'b00, u[11:6]};
      s.b[2] = CONT | {2'b00, u[5:0]};
      s.n    = 3'd3;
    end
    return s;
  endfunction

  function automatic seg_t enc_pair(input logic [15:0] hi, input logic [15:0] lo);
    seg_t        s;
    logic [20:0] cp;
    cp     = 21'h10000 + {1'b0, hi[9:0], lo[9:0]};
    s.b[0] = LEAD4 | {5'b00000, cp[20:18]};
    s.b[1] = CONT | {2'b00, cp[17:12]};
    s.b[2] = CONT | {2'b00, cp[11:6]};
    s.b[3] = CONT | {2'b00, cp[5:0]};
    s.n    = 3'd4;
    return s;
  endfunction

  function automatic seg_t be_unit(input logic [15:0] u);
    seg_t s;
    s      = '0;
    s.b[0] = u[15:8];
    s.b[1] = u[7:0];
    s.n    = 3'd2;
    return s;
  endfunction

  // place a segment after the n bytes already in the list
  function automatic byte_list_t put_seg(input byte_list_t l, input logic [CNT_W-1:0] n,
                                         input seg_t s);
    byte_list_t       r;
    logic [CNT_W-1:0] idx;
    r = l;
    for (int i = 0; i < SEG_BYTES; i++) begin
      idx = n + CNT_W'(i);
      if (CNT_W'(i) < s.n && idx < CNT_W'(MAX_BYTES)) begin
        r[idx] = s.b[i];
      end
    end
    return r;
  endfunction

  logic is_high;
  logic is_low;
  logic held;
  logic hold;
  seg_t mark;
  seg_t held_seg;
  seg_t unit_seg;
  logic [CNT_W-1:0] n1;
  logic [CNT_W-1:0] n2;

  assign is_high = (item.code_unit[15:10] == HIGH_SURR_TAG);
  assign is_low  = (item.code_unit[15:10] == LOW_SURR_TAG);
  // a first unit drops whatever an unclosed earlier text left held
  assign held    = held_valid && !item.first_unit;

  always_comb begin
    mark     = '0;
    held_seg = '0;
    unit_seg = '0;
    hold     = 1'b0;

    if (item.first_unit) begin
      if (emit_utf8) begin
        mark.b[0] = UTF8_BOM0;
        mark.b[1] = UTF8_BOM1;
        mark.b[2] = UTF8_BOM2;
        mark.n    = 3'd3;
      end else begin
        mark.b[0] = UTF16_BOM0;
        mark.b[1] = UTF16_BOM1;
        mark.n    = 3'd2;
      end
    end

    if (emit_utf8) begin
      if (held && is_low) begin
        // pair completes, low surrogate consumed
        held_seg = enc_pair(held_high, item.code_unit);
      end else begin
        if (held) begin
          held_seg = enc_unit(held_high);
        end
        if (is_high && !item.last_unit) begin
          hold = 1'b1;
        end else begin
          unit_seg = enc_unit(item.code_unit);
        end
      end
    end else begin
      if (held) begin
        held_seg = be_unit(held_high);
      end
      unit_seg = be_unit(item.code_unit);
    end
  end

  assign n1 = mark.n + held_seg.n;
  assign n2 = n1 + unit_seg.n;

  always_comb begin
    res.bytes = put_seg(put_seg(put_seg('0, '0, mark), mark.n, held_seg), n1, unit_seg);
    res.count = n2;
    res.hold  = hold;
  end

endmodule

FILE: rtl/utf16_to_utf8_byte_encoder.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_byte_encoder
// Streams UTF-16 code units in and UTF-8 (or big-endian UTF-16) bytes out.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_item carries one code unit per request,
// with first_unit and last_unit marking the text's bounds. Output channel
// out_valid/out_ready/out_item gives one byte per request; run_end flags the
// last byte caused by an input unit. A unit is encoded in the cycle it is
// accepted into a six-byte buffer, which drains one byte per cycle into the
// output register while the receiver accepts; each byte passes the buffer
// and then the output register. The next unit is taken in the cycle the
// last byte of the previous one moves out, so sustained rate is one byte
// per cycle while out_ready holds. A unit that is only held (high surrogate)
// produces no bytes apart from the byte order mark of a first unit.
// If the receiver stalls, the output register and buffer hold their bytes
// and in_ready drops once the buffer cannot be emptied. Reset (rst, sync)
// empties the buffer and output, drops any held surrogate and selects UTF-8.
// Register emit_utf8 sits at byte address 0 of the APB port; write it only
// while the block is idle.
// ----------------------------------------------------------------------------
module utf16_to_utf8_byte_encoder
  import u16u8_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic             emit_utf8;
  logic             held_valid;
  logic [15:0]      held_high;
  enc_res_t         enc;

  logic             buf_valid;
  byte_list_t       bytes;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] pos;

  logic             in_take;
  logic             load_out;
  logic             last_move;
  logic             reg_sel;

  u16u8_encode u_encode (
    .item       (in_item),
    .emit_utf8  (emit_utf8),
    .held_valid (held_valid),
    .held_high  (held_high),
    .res        (enc)
  );

  // config port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1:2] == REG_EMIT_UTF8);
  assign prdata  = reg_sel ? {{(DATA_W-1){1'b0}}, emit_utf8} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_utf8 <= 1'b1;
    end else if (psel && penable && pwrite && reg_sel) begin
      emit_utf8 <= pwdata[0];
    end
  end

  assign load_out  = buf_valid && (!out_valid || out_ready);
  assign last_move = load_out && (pos == count - CNT_W'(1));
  assign in_ready  = !buf_valid || last_move;
  assign in_take   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_take) begin
      held_valid <= enc.hold;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      held_high <= in_item.code_unit;
    end
  end

  // byte buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      pos       <= '0;
    end else if (in_take && enc.count != '0) begin
      buf_valid <= 1'b1;
      pos       <= '0;
    end else if (last_move) begin
      buf_valid <= 1'b0;
    end else if (load_out) begin
      pos <= pos + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      bytes <= enc.bytes;
      count <= enc.count;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item.out_byte <= bytes[pos];
      out_item.run_end  <= (pos == count - CNT_W'(1));
    end
  end

endmodule
